[sv/shift_queue_with_search_max_defines.svh]
// ----------------------------------------------------------------------------
// Shift queue assertion macros
// Concurrent assertion helpers; expect clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef SHIFT_QUEUE_WITH_SEARCH_MAX_DEFINES_SVH
`define SHIFT_QUEUE_WITH_SEARCH_MAX_DEFINES_SVH

// same-cycle implication
`define SQSM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SQSM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sqsm_pkg.sv]
// ----------------------------------------------------------------------------
// Shift queue package
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sqsm_pkg;

  localparam int DEPTH   = 8;
  localparam int WORD_W  = 32;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 4;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OUT_W   = STAT_W + 1 + WORD_W + OCC_W;
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ    = 3'd0,
    ACT_DEQ    = 3'd1,
    ACT_SEARCH = 3'd2,
    ACT_MAX    = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } sts_t;

endpackage

[sv/sqsm_ctrl.sv]
// ----------------------------------------------------------------------------
// Shift queue controller
// Sequences load, execute, scan and result hand-off for one request.
// ----------------------------------------------------------------------------
`include "shift_queue_with_search_max_defines.svh"

module sqsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  sqsm_pkg::sts_t    sts,
  output sqsm_pkg::cmd_t    cmd
);

  sqsm_pkg::state_t state_r;
  sqsm_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == sqsm_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sqsm_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = sqsm_pkg::S_EXEC;
      end
      sqsm_pkg::S_EXEC: begin
        state_nxt = sts.need_scan ? sqsm_pkg::S_SCAN : sqsm_pkg::S_EMIT;
      end
      sqsm_pkg::S_SCAN: begin
        if (sts.scan_last) state_nxt = sqsm_pkg::S_EMIT;
      end
      sqsm_pkg::S_EMIT: begin
        if (slot_free) state_nxt = sqsm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = sqsm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      sqsm_pkg::S_IDLE: cmd.load = in_tvalid;
      sqsm_pkg::S_EXEC: cmd.exec = 1'b1;
      sqsm_pkg::S_SCAN: cmd.step = 1'b1;
      sqsm_pkg::S_EMIT: cmd.emit = slot_free;
      default:          cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqsm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SQSM_ASSERT_NEXT(a_accept_exec, in_tvalid && in_tready, state_r == sqsm_pkg::S_EXEC, "accepted request not executed")
  `SQSM_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_r, "emitted result not presented")
  `SQSM_ASSERT_NEXT(a_hold_pending, state_r == sqsm_pkg::S_EMIT && out_valid_r && !out_tready, state_r == sqsm_pkg::S_EMIT, "pending result overwritten")

endmodule

[sv/sqsm_dp.sv]
// ----------------------------------------------------------------------------
// Shift queue datapath
// Entry shift line, count, one-entry-per-cycle scan unit and result register.
// ----------------------------------------------------------------------------
module sqsm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [31:0]                   in_tdata,
  input  logic [2:0]                    in_tuser,
  input  sqsm_pkg::cmd_t                cmd,
  output sqsm_pkg::sts_t                sts,
  output logic [sqsm_pkg::OUT_TW-1:0]   out_tdata
);

  logic signed [sqsm_pkg::WORD_W-1:0] entries_r   [sqsm_pkg::DEPTH];
  logic signed [sqsm_pkg::WORD_W-1:0] entries_nxt [sqsm_pkg::DEPTH];
  logic [sqsm_pkg::CNT_W-1:0]         count_r;
  logic [sqsm_pkg::CNT_W-1:0]         count_nxt;
  logic [sqsm_pkg::ACT_W-1:0]         op_r;
  logic signed [sqsm_pkg::WORD_W-1:0] value_r;
  logic [sqsm_pkg::IDX_W-1:0]         idx_r;
  logic [sqsm_pkg::IDX_W-1:0]         idx_nxt;
  logic                               found_r;
  logic                               found_nxt;
  logic signed [sqsm_pkg::WORD_W-1:0] largest_r;
  logic signed [sqsm_pkg::WORD_W-1:0] largest_nxt;
  sqsm_pkg::status_t                  status_r;
  sqsm_pkg::status_t                  status_nxt;
  logic [sqsm_pkg::OUT_W-1:0]         out_r;
  logic signed [sqsm_pkg::WORD_W-1:0] cur_entry;
  logic                               is_empty;
  logic                               is_full;
  logic                               is_scan_op;

  assign cur_entry  = entries_r[idx_r];
  assign is_empty   = (count_r == '0);
  assign is_full    = (count_r == sqsm_pkg::CNT_W'(sqsm_pkg::DEPTH));
  assign is_scan_op = (op_r == sqsm_pkg::ACT_SEARCH) || (op_r == sqsm_pkg::ACT_MAX);

  assign sts.need_scan = is_scan_op && !is_empty;
  assign sts.scan_last = (sqsm_pkg::CNT_W'(idx_r) == count_r - sqsm_pkg::CNT_W'(1));

  always_comb begin
    entries_nxt = entries_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    largest_nxt = largest_r;
    status_nxt  = status_r;
    if (cmd.exec) begin
      status_nxt  = sqsm_pkg::ST_DONE;
      found_nxt   = 1'b0;
      largest_nxt = '0;
      idx_nxt     = '0;
      case (op_r)
        sqsm_pkg::ACT_ENQ: begin
          if (is_full) begin
            status_nxt = sqsm_pkg::ST_FULL;
          end else begin
            entries_nxt[count_r[sqsm_pkg::IDX_W-1:0]] = value_r;
            count_nxt = count_r + sqsm_pkg::CNT_W'(1);
          end
        end
        sqsm_pkg::ACT_DEQ: begin
          if (is_empty) begin
            status_nxt = sqsm_pkg::ST_EMPTY;
          end else begin
            for (int i = 0; i < sqsm_pkg::DEPTH - 1; i++) begin
              entries_nxt[i] = entries_r[i+1];
            end
            entries_nxt[sqsm_pkg::DEPTH-1] = '0;
            count_nxt = count_r - sqsm_pkg::CNT_W'(1);
          end
        end
        sqsm_pkg::ACT_SEARCH: begin
          if (is_empty) status_nxt = sqsm_pkg::ST_EMPTY;
        end
        sqsm_pkg::ACT_MAX: begin
          if (is_empty) begin
            status_nxt = sqsm_pkg::ST_EMPTY;
          end else begin
            largest_nxt = entries_r[0];
          end
        end
        sqsm_pkg::ACT_CLEAR: begin
          for (int i = 0; i < sqsm_pkg::DEPTH; i++) begin
            entries_nxt[i] = '0;
          end
          count_nxt = '0;
        end
        default: begin
          status_nxt = sqsm_pkg::ST_DONE;
        end
      endcase
    end else if (cmd.step) begin
      if ((op_r == sqsm_pkg::ACT_SEARCH) && (cur_entry == value_r)) found_nxt = 1'b1;
      if ((op_r == sqsm_pkg::ACT_MAX) && (cur_entry > largest_r)) largest_nxt = cur_entry;
      idx_nxt = idx_r + sqsm_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < sqsm_pkg::DEPTH; i++) begin
        entries_r[i] <= '0;
      end
    end else begin
      count_r   <= count_nxt;
      entries_r <= entries_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser;
      value_r <= in_tdata;
    end
    idx_r     <= idx_nxt;
    found_r   <= found_nxt;
    largest_r <= largest_nxt;
    status_r  <= status_nxt;
    if (cmd.emit) begin
      out_r <= {sqsm_pkg::OCC_W'(count_r), largest_r, found_r, status_r};
    end
  end

  assign out_tdata = sqsm_pkg::OUT_TW'(out_r);

endmodule

[sv/shift_queue_with_search_max.sv]
// ----------------------------------------------------------------------------
// Shift queue with search and maximum
// Eight-entry shift queue of signed words, one request in, one result out.
// ----------------------------------------------------------------------------
// Usage: send a request on in_*: in_tuser carries the action (enqueue,
// dequeue, search, largest, clear), in_tdata the value. Each request gives
// one result on out_*: status, found flag, largest value and occupancy.
// Timing: a request is taken only while the block is idle. Enqueue, dequeue,
// clear and requests on an empty queue pass from acceptance through the execute
// and emit states to the result register; search and largest add a scan state
// between them that reads one held entry per cycle, up to the count.
// A new request is taken only once the previous one has left the emit state.
// The block takes the next request while a result still waits in the output
// register; if out_tready stays low, the following result holds inside and
// in_tready stays low until the register frees up.
// Reset: rst_n low clears all entries, the count and any pending result.
// ----------------------------------------------------------------------------
module shift_queue_with_search_max (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // value
  input  logic [2:0]                  in_tuser,   // action
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sqsm_pkg::OUT_TW-1:0] out_tdata   // status, found, largest, occupancy
);

  sqsm_pkg::cmd_t cmd;
  sqsm_pkg::sts_t sts;

  sqsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sqsm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule
